/* hw/rtl/csc_pkg.sv */
// shared types, constants and register codes of the password checksum checker
package csc_pkg;

    localparam int CodeW = 6;
    localparam int ByteW = 8;
    localparam int CfgIdxW = 3;

    localparam logic [ByteW-1:0] POLY_HIGH   = 8'h84;
    localparam logic [ByteW-1:0] POLY_LOW    = 8'h08;
    localparam logic [ByteW-1:0] CARRY_LIMIT = 8'hE5;
    localparam logic [ByteW-1:0] ROTATE_INIT = 8'h01;

    localparam logic [CfgIdxW-1:0] CFG_CHECK_HIGH = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CHECK_LOW  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_ADD    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY_CHAIN  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_KEY_XOR    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_KEY_ROTATE = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_KEY_COUNT  = 3'd6;

    typedef struct packed {
        logic [ByteW-1:0] lfsr_high;
        logic [ByteW-1:0] lfsr_low;
        logic [ByteW-1:0] acc_add;
        logic [ByteW-1:0] acc_chain;
        logic [ByteW-1:0] acc_xor;
        logic [ByteW-1:0] acc_rotate;
        logic [ByteW-1:0] acc_count;
    } t_state;

    localparam t_state STATE_INIT = '{
        lfsr_high:  8'h00,
        lfsr_low:   8'h00,
        acc_add:    8'h00,
        acc_chain:  8'h00,
        acc_xor:    8'h00,
        acc_rotate: ROTATE_INIT,
        acc_count:  8'h00
    };

endpackage

/* hw/rtl/csc_char_if.sv */
// input channel: one character code word per handshake
interface csc_char_if
    import csc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CodeW-1:0] char_code;
    logic             last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* hw/rtl/csc_res_if.sv */
// result channel: final checksum bytes and match flags per password
interface csc_res_if
    import csc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] crc_high;
    logic [ByteW-1:0] crc_low;
    logic [ByteW-1:0] add_sum;
    logic [ByteW-1:0] chain_sum;
    logic [ByteW-1:0] xor_sum;
    logic [ByteW-1:0] rotate_sum;
    logic [ByteW-1:0] count_sum;
    logic             check_match;
    logic             key_match;

    modport source (output valid, output crc_high, output crc_low, output add_sum,
                    output chain_sum, output xor_sum, output rotate_sum,
                    output count_sum, output check_match, output key_match,
                    input ready);
    modport sink   (input valid, input crc_high, input crc_low, input add_sum,
                    input chain_sum, input xor_sum, input rotate_sum,
                    input count_sum, input check_match, input key_match,
                    output ready);
endinterface

/* hw/rtl/csc_cfg.sv */
// configuration registers: check bytes and key sums
module csc_cfg
    import csc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [ByteW-1:0]   i_cfg_data,
    output t_state             o_target
);

    t_state r_target;
    t_state n_target;

    always_comb begin
        n_target = r_target;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHECK_HIGH: n_target.lfsr_high  = i_cfg_data;
                CFG_CHECK_LOW:  n_target.lfsr_low   = i_cfg_data;
                CFG_KEY_ADD:    n_target.acc_add    = i_cfg_data;
                CFG_KEY_CHAIN:  n_target.acc_chain  = i_cfg_data;
                CFG_KEY_XOR:    n_target.acc_xor    = i_cfg_data;
                CFG_KEY_ROTATE: n_target.acc_rotate = i_cfg_data;
                CFG_KEY_COUNT:  n_target.acc_count  = i_cfg_data;
                default:        n_target = r_target;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else begin
            r_target <= n_target;
        end
    end

    assign o_target = r_target;

endmodule

/* hw/rtl/csc_update.sv */
// one character step: 16-bit shift register fold over two bytes and carry-chained sums
module csc_update
    import csc_pkg::*;
(
    input  t_state           i_state,
    input  logic [CodeW-1:0] i_code,
    output t_state           o_state
);

    logic [ByteW-1:0] code8;
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    logic             out_hi;
    logic             out_lo;
    logic             c0;
    logic             c3;
    logic [ByteW:0]   s_add;
    logic [ByteW:0]   s_chain;
    logic [ByteW:0]   s_rot;
    logic [ByteW-1:0] rot;
    logic [3:0]       pop;

    assign code8 = {{(ByteW-CodeW){1'b0}}, i_code};

    // msb first over all eight bits of the code
    always_comb begin
        hi = i_state.lfsr_high;
        lo = i_state.lfsr_low;
        out_hi = 1'b0;
        out_lo = 1'b0;
        for (int b = ByteW - 1; b >= 0; b--) begin
            out_hi = hi[0];
            out_lo = lo[0];
            hi = {code8[b], hi[ByteW-1:1]};
            lo = {out_hi, lo[ByteW-1:1]};
            if (out_lo) begin
                hi = hi ^ POLY_HIGH;
                lo = lo ^ POLY_LOW;
            end
        end
    end

    always_comb begin
        pop = '0;
        for (int b = 0; b < CodeW; b++) begin
            pop = pop + {3'b000, i_code[b]};
        end
    end

    assign c0      = (hi >= CARRY_LIMIT);
    assign s_add   = {1'b0, code8} + {1'b0, i_state.acc_add} + {{ByteW{1'b0}}, c0};
    assign s_chain = {1'b0, i_state.acc_chain} + {1'b0, lo} + {{ByteW{1'b0}}, s_add[ByteW]};
    assign rot     = {s_chain[ByteW], i_state.acc_rotate[ByteW-1:1]};
    assign c3      = i_state.acc_rotate[0];
    assign s_rot   = {1'b0, rot} + {1'b0, code8} + {{ByteW{1'b0}}, c3};

    always_comb begin
        o_state.lfsr_high  = hi;
        o_state.lfsr_low   = lo;
        o_state.acc_add    = s_add[ByteW-1:0];
        o_state.acc_chain  = s_chain[ByteW-1:0];
        o_state.acc_xor    = i_state.acc_xor ^ code8;
        o_state.acc_rotate = s_rot[ByteW-1:0];
        o_state.acc_count  = i_state.acc_count + {{(ByteW-1){1'b0}}, s_rot[ByteW]}
                             + {4'b0000, pop};
    end

endmodule

/* hw/rtl/password_checksum_checker_top.sv */
// top level of the password checksum checker
//
//  channel  | dir | word contents                                   | handshake
//  i_char   | in  | char_code[5:0], last                            | valid/ready
//  o_res    | out | seven checksum bytes, check_match, key_match    | valid/ready
//  i_cfg_*  | in  | write enable, index[2:0], data[7:0]             | write only
//
// one character word per cycle sustained unless a last word waits on a full result register;
// a result word is valid once the last word has passed the input register and the result
// register around the combinational update logic
// the input register holds a last word only while the result register is full
// reset is synchronous; it loads the initial running sums and clears the config registers
module password_checksum_checker_top
    import csc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    csc_char_if.sink           i_char,
    csc_res_if.source          o_res,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [ByteW-1:0]   i_cfg_data
);

    logic             r_in_valid;
    logic [CodeW-1:0] r_in_code;
    logic             r_in_last;
    t_state           r_state;
    t_state           n_state;
    t_state           upd_state;
    t_state           target;
    logic             r_out_valid;
    t_state           r_out;
    logic             r_check_match;
    logic             r_key_match;
    logic             out_free;
    logic             fire;

    csc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_target   (target)
    );

    csc_update u_update (
        .i_state (r_state),
        .i_code  (r_in_code),
        .o_state (upd_state)
    );

    assign out_free     = !r_out_valid || o_res.ready;
    assign fire         = r_in_valid && (!r_in_last || out_free);
    assign i_char.ready = !r_in_valid || fire;

    always_comb begin
        n_state = r_state;
        if (fire) begin
            n_state = r_in_last ? STATE_INIT : upd_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_INIT;
        end else begin
            r_state <= n_state;
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (fire && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_code <= i_char.char_code;
            r_in_last <= i_char.last;
        end
        if (fire && r_in_last) begin
            r_out         <= upd_state;
            r_check_match <= (upd_state.lfsr_high == target.lfsr_high)
                             && (upd_state.lfsr_low == target.lfsr_low);
            r_key_match   <= (upd_state.acc_add == target.acc_add)
                             && (upd_state.acc_chain == target.acc_chain)
                             && (upd_state.acc_xor == target.acc_xor)
                             && (upd_state.acc_rotate == target.acc_rotate)
                             && (upd_state.acc_count == target.acc_count);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.crc_high    = r_out.lfsr_high;
    assign o_res.crc_low     = r_out.lfsr_low;
    assign o_res.add_sum     = r_out.acc_add;
    assign o_res.chain_sum   = r_out.acc_chain;
    assign o_res.xor_sum     = r_out.acc_xor;
    assign o_res.rotate_sum  = r_out.acc_rotate;
    assign o_res.count_sum   = r_out.acc_count;
    assign o_res.check_match = r_check_match;
    assign o_res.key_match   = r_key_match;

endmodule

/* hw/rtl/csc_checker.sv */
// port-level assertions for the password checksum checker, bound to the top
module csc_checker
    import csc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [ByteW-1:0] i_out_crc_high
);

    // results are empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_crc_high))
        else $error("stalled result word changed");

    // a new result follows a last word that was taken earlier
    a_rise_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result without a last word");

    // input stalls only under result back-pressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without back-pressure");

endmodule

bind password_checksum_checker_top csc_checker u_csc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_char.valid),
    .i_in_ready     (i_char.ready),
    .i_in_last      (i_char.last),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_crc_high (o_res.crc_high)
);
